### hdl/lpd_pkg.sv
// Shared types and constants for the length-prefixed deframer.
// Used by every module under hdl/; no dependencies.
`default_nettype none

package lpd_pkg;

	localparam int LPD_HDR_BYTES   = 8;
	localparam int LPD_POS_W       = 33;
	localparam int LPD_QUEUE_DEPTH = 4;
	localparam int LPD_TDATA_W     = 32;
	localparam int LPD_TUSER_W     = 2;

	typedef enum logic [1:0] {
		LPD_ST_OK       = 2'd0,
		LPD_ST_SHORT    = 2'd1,
		LPD_ST_MISMATCH = 2'd2
	} lpd_status_t;

	// one classified byte, as queued between front and back
	typedef struct packed {
		logic [7:0]  body_byte;
		logic        body_valid;
		logic        section;
		logic [15:0] type_code;
		logic        frame_done;
		lpd_status_t status;
	} lpd_item_t;

	// queue handshake toward either side
	typedef struct packed {
		logic full;
		logic empty;
	} lpd_qstat_t;

endpackage

`default_nettype wire

### hdl/lpd_front.sv
// Front part: accepts frame bytes, captures the header and classifies each byte.
// Depends on lpd_pkg; pushes one lpd_item_t per transfer into the queue.
`default_nettype none

module lpd_front import lpd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,    // [7:0] data_byte
	input  wire logic       s_tlast,    // last_byte
	input  wire lpd_qstat_t qstat,
	output logic            push,
	output lpd_item_t       push_item
);

	localparam logic [LPD_POS_W-1:0] POS_MAX = {LPD_POS_W{1'b1}};
	localparam logic [LPD_POS_W:0]   HDR_W1  = (LPD_POS_W+1)'(LPD_HDR_BYTES);
	localparam logic [LPD_POS_W-1:0] HDR_W   = LPD_POS_W'(LPD_HDR_BYTES);

	logic [LPD_POS_W-1:0] pos_q;
	logic [15:0]          type_q;
	logic [15:0]          idlen_q;
	logic [31:0]          pllen_q;

	logic [15:0]          type_n;
	logic [15:0]          idlen_n;
	logic [31:0]          pllen_n;
	logic [LPD_POS_W-1:0] pos_n;
	logic                 in_hdr;
	logic [LPD_POS_W:0]   total;
	logic [LPD_POS_W:0]   expect_len;
	logic [LPD_POS_W-1:0] id_end;

	assign s_tready = !qstat.full;
	assign push     = s_tvalid && s_tready;

	assign in_hdr = (pos_q[LPD_POS_W-1:3] == '0);

	always_comb begin
		type_n  = type_q;
		idlen_n = idlen_q;
		pllen_n = pllen_q;
		if (in_hdr) begin
			case (pos_q[2:1])
				2'd0:    type_n  = {type_q[7:0], s_tdata};
				2'd1:    idlen_n = {idlen_q[7:0], s_tdata};
				default: pllen_n = {pllen_q[23:0], s_tdata};
			endcase
		end
	end

	assign pos_n      = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign total      = {1'b0, pos_q} + 1'b1;
	assign expect_len = HDR_W1 + (LPD_POS_W+1)'(idlen_n) + (LPD_POS_W+1)'(pllen_n);
	assign id_end     = LPD_POS_W'(idlen_q) + HDR_W;

	always_comb begin
		push_item            = '0;
		push_item.type_code  = type_n;
		push_item.frame_done = s_tlast;
		push_item.status     = LPD_ST_OK;
		if (!in_hdr) begin
			push_item.body_byte  = s_tdata;
			push_item.body_valid = 1'b1;
			push_item.section    = (pos_q >= id_end);
		end
		if (s_tlast) begin
			if (total < HDR_W1)
				push_item.status = LPD_ST_SHORT;
			else if (total != expect_len)
				push_item.status = LPD_ST_MISMATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			type_q  <= '0;
			idlen_q <= '0;
			pllen_q <= '0;
		end else if (push) begin
			if (s_tlast) begin
				pos_q   <= '0;
				type_q  <= '0;
				idlen_q <= '0;
				pllen_q <= '0;
			end else begin
				pos_q   <= pos_n;
				type_q  <= type_n;
				idlen_q <= idlen_n;
				pllen_q <= pllen_n;
			end
		end
	end

	// every frame restarts from a cleared header
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push && s_tlast |=> pos_q == '0 && idlen_q == '0 && pllen_q == '0)
		else $error("state not cleared after last byte");

	// a short frame can only end inside the header, before its eighth byte
	a_short_in_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_item.status == LPD_ST_SHORT |-> in_hdr && pos_q[2:0] != 3'd7)
		else $error("short status outside header");

endmodule

`default_nettype wire

### hdl/lpd_queue.sv
// Short queue of classified bytes between front and back.
// Depends on lpd_pkg for lpd_item_t and lpd_qstat_t.
`default_nettype none

module lpd_queue import lpd_pkg::*; #(
	parameter int DEPTH = LPD_QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire lpd_item_t push_item,
	input  wire logic      pop,
	output lpd_item_t      pop_item,
	output lpd_qstat_t     qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	lpd_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);
	assign pop_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty |-> !pop)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

### hdl/lpd_back.sv
// Back part: drains the queue into the registered output stream.
// Depends on lpd_pkg; packs lpd_item_t into m_tdata, m_tuser and m_tlast.
`default_nettype none

module lpd_back import lpd_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lpd_qstat_t              qstat,
	input  wire lpd_item_t               pop_item,
	output logic                         pop,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [LPD_TDATA_W-1:0]       m_tdata,   // [7:0] body_byte, [23:8] type_code,
	                                                // [25:24] status, rest zero
	output logic [LPD_TUSER_W-1:0]       m_tuser,   // [0] body_valid, [1] section
	output logic                         m_tlast    // frame_done
);

	logic      valid_q;
	lpd_item_t out_q;

	assign pop = !qstat.empty && (!valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || m_tready)
			valid_q <= !qstat.empty;
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= pop_item;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {(LPD_TDATA_W-26)'(0), out_q.status, out_q.type_code, out_q.body_byte};
	assign m_tuser  = {out_q.section, out_q.body_valid};
	assign m_tlast  = out_q.frame_done;

	// a status other than ok only travels with the last transfer of a frame
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && out_q.status != LPD_ST_OK |-> out_q.frame_done)
		else $error("error status without frame end");

endmodule

`default_nettype wire

### hdl/length_prefixed_deframer_core.sv
// Length-prefixed frame deframer: one result transfer per input byte.
// An accepted byte goes into the queue, then into the output register behind m_tvalid.
// Throughput: one byte per cycle while the queue is not full; the front classifies
// a byte in the cycle it is taken.
// s_tready drops only when the queue is full under output backpressure.
// Reset (arst_n low, asynchronous): header state, queue and output valid cleared.
// Depends on lpd_pkg, lpd_front, lpd_queue, lpd_back.
`default_nettype none

module length_prefixed_deframer_core import lpd_pkg::*; #(
	parameter int QUEUE_DEPTH = LPD_QUEUE_DEPTH
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [7:0]              s_tdata,   // [7:0] data_byte
	input  wire logic                    s_tlast,   // last_byte
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [LPD_TDATA_W-1:0]       m_tdata,   // [7:0] body_byte, [23:8] type_code,
	                                                // [25:24] status, rest zero
	output logic [LPD_TUSER_W-1:0]       m_tuser,   // [0] body_valid, [1] section
	output logic                         m_tlast    // frame_done
);

	lpd_qstat_t qstat;
	logic       push;
	logic       pop;
	lpd_item_t  push_item;
	lpd_item_t  pop_item;

	lpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.qstat     (qstat),
		.push      (push),
		.push_item (push_item)
	);

	lpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.qstat     (qstat)
	);

	lpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_item (pop_item),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

### dv/lpd_checker.sv
// Scoreboard for length_prefixed_deframer_core: watches both stream channels,
// predicts each result transfer from the accepted input bytes and compares field by field.
// Depends on lpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpd_checker import lpd_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [7:0]             s_tdata,
	input  wire logic                   s_tlast,
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [LPD_TDATA_W-1:0] m_tdata,
	input  wire logic [LPD_TUSER_W-1:0] m_tuser,
	input  wire logic                   m_tlast,
	output int                          errors,
	output int                          pending
);

	localparam logic [LPD_POS_W-1:0] HDR_LEN = LPD_POS_W'(LPD_HDR_BYTES);
	localparam logic [LPD_POS_W-1:0] POS_MAX = '1;

	// deframer state as seen from the byte stream
	logic [LPD_POS_W-1:0] frame_pos   = '0;
	logic [15:0]          frame_type  = '0;
	logic [15:0]          id_len      = '0;
	logic [31:0]          pay_len     = '0;

	lpd_item_t expected_q[$];
	int        result_idx = 0;

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic lpd_item_t deframe_byte(input logic [7:0] b, input logic last);
		lpd_item_t          r;
		logic [LPD_POS_W:0] total;
		logic [LPD_POS_W:0] declared;
		r = '0;
		if (frame_pos < 2) begin
			frame_type = {frame_type[7:0], b};
		end else if (frame_pos < 4) begin
			id_len = {id_len[7:0], b};
		end else if (frame_pos < HDR_LEN) begin
			pay_len = {pay_len[23:0], b};
		end else begin
			r.body_byte  = b;
			r.body_valid = 1'b1;
			r.section    = ((frame_pos - HDR_LEN) >= id_len);
		end
		r.type_code = frame_type;
		total = {1'b0, frame_pos} + 1'b1;
		if (frame_pos != POS_MAX)
			frame_pos = frame_pos + 1'b1;
		if (last) begin
			declared     = HDR_LEN + id_len + pay_len;
			r.frame_done = 1'b1;
			if (total < HDR_LEN)
				r.status = LPD_ST_SHORT;
			else if (total != declared)
				r.status = LPD_ST_MISMATCH;
			else
				r.status = LPD_ST_OK;
			frame_pos   = '0;
			frame_type  = '0;
			id_len      = '0;
			pay_len     = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: result %0d: %s", $time, result_idx, msg);
		errors = errors + 1;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
	endtask

	always @(posedge clk) begin
		lpd_item_t want;
		if (arst_n) begin
			// a result never leaves in the cycle its byte is taken, so pop before push
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result transfer with nothing outstanding");
				end else begin
					want = expected_q.pop_front();
					check_field("body_byte", m_tdata[7:0], want.body_byte);
					check_field("type_code", m_tdata[23:8], want.type_code);
					check_field("status", m_tdata[25:24], want.status);
					check_field("tdata padding", m_tdata[LPD_TDATA_W-1:26], 0);
					check_field("body_valid", m_tuser[0], want.body_valid);
					check_field("section", m_tuser[1], want.section);
					check_field("frame_done", m_tlast, want.frame_done);
				end
				result_idx++;
			end
			if (s_tvalid && s_tready)
				expected_q.insert(expected_q.size(), deframe_byte(s_tdata, s_tlast));
			pending <= expected_q.size();
		end
	end

endmodule

`default_nettype wire

### dv/tb_length_prefixed_deframer_core.sv
// Testbench top for length_prefixed_deframer_core: drives framed byte streams with
// random idling on both sides and gives the verdict from lpd_checker's error count.
// Depends on lpd_pkg, length_prefixed_deframer_core and lpd_checker.
`timescale 1ns / 1ps
`default_nettype none

module tb_length_prefixed_deframer_core;
	import lpd_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int TAIL_CYCLES  = 12;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [LPD_TDATA_W-1:0] m_tdata;
	logic [LPD_TUSER_W-1:0] m_tuser;
	logic                   m_tlast;

	int errors;
	int pending;
	int tx_idle_pct  = 0;
	int rx_idle_pct  = 0;
	int items_sent   = 0;
	int stall_cycles = 0;

	logic [7:0] frame_bytes[$];

	always #5 clk = ~clk;

	length_prefixed_deframer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lpd_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (errors),
		.pending  (pending)
	);

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// no transfer on either side for too long means the block is stuck
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("length_prefixed_deframer_core test failed");
			$finish;
		end
	end

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++) begin
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= frame_bytes[i];
			s_tlast  <= (i == frame_bytes.size() - 1);
			do @(posedge clk); while (!s_tready);
			items_sent++;
		end
	endtask

	// hold off the sender until every outstanding result has come out
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic build_random_frame();
		int          kind;
		int          id_n;
		int          pay_n;
		int          n_body;
		int          keep;
		logic [15:0] ftype;
		logic [15:0] hid;
		logic [31:0] hpay;
		kind   = $urandom_range(0, 99);
		ftype  = 16'($urandom);
		id_n   = $urandom_range(0, 6);
		pay_n  = $urandom_range(0, 24);
		hid    = 16'(id_n);
		hpay   = 32'(pay_n);
		n_body = id_n + pay_n;
		if (kind >= 95) begin
			// wide declared lengths, short body
			hid    = 16'($urandom);
			hpay   = $urandom;
			n_body = $urandom_range(0, 6);
		end else if (kind >= 80 && kind < 90 && n_body > 0) begin
			n_body = $urandom_range(0, n_body - 1);
		end else if (kind >= 70 && kind < 80) begin
			n_body = n_body + $urandom_range(1, 4);
		end
		frame_bytes = {ftype[15:8], ftype[7:0], hid[15:8], hid[7:0],
			hpay[31:24], hpay[23:16], hpay[15:8], hpay[7:0]};
		for (int i = 0; i < n_body; i++)
			frame_bytes.insert(frame_bytes.size(), 8'($urandom));
		if (kind >= 90 && kind < 95) begin
			// frame ends inside the header
			keep = $urandom_range(1, 7);
			while (frame_bytes.size() > keep)
				void'(frame_bytes.pop_back());
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 31;
		rx_idle_pct = 54;

		// one-byte frame: too short, type shows the lone byte
		frame_bytes = {8'hFF};
		send_frame();
		// frame ending mid-header
		frame_bytes = {8'hAB, 8'hCD, 8'h80, 8'h01};
		send_frame();
		// zero declared lengths plus one trailing byte: excess, tagged payload
		frame_bytes = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
		send_frame();
		// one identifier byte, three payload bytes, lengths match
		frame_bytes = {8'h12, 8'h34, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h03,
			8'h5A, 8'hA5, 8'h00, 8'hFF};
		send_frame();

		items_sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 31;
					rx_idle_pct = 54;
				end
				1: begin
					tx_idle_pct = 54;
					rx_idle_pct = 31;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			while (items_sent < (RANDOM_ITEMS / 3) * (phase + 1)) begin
				build_random_frame();
				send_frame();
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("length_prefixed_deframer_core test passed");
		else
			$display("length_prefixed_deframer_core test failed");
		$finish;
	end

endmodule

`default_nettype wire
